### src/ppc_pkg.sv
// Shared types and constants for the positional PID controller.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package ppc_pkg;

   localparam int GAIN_W            = 16;
   localparam int LIMIT_W           = 15;
   localparam int SAMPLE_W          = 16;
   localparam int ERR_W             = SAMPLE_W + 1;
   localparam int DIFF_W            = ERR_W + 1;
   localparam int ACTION_W          = 2;
   localparam int CSR_IDX_W         = 3;
   localparam int CSR_DATA_W        = 16;
   localparam int DEFAULT_FRAC_BITS = 8;

   localparam logic [GAIN_W-1:0]  KP_RESET        = 16'd256;
   localparam logic [GAIN_W-1:0]  KI_RESET        = 16'd0;
   localparam logic [GAIN_W-1:0]  KD_RESET        = 16'd0;
   localparam logic [LIMIT_W-1:0] INT_LIMIT_RESET = 15'd32767;
   localparam logic [LIMIT_W-1:0] OUT_LIMIT_RESET = 15'd32767;

   typedef enum logic [ACTION_W-1:0] {
      ACT_COMPUTE   = 2'd0,
      ACT_CLEAR_ALL = 2'd1,
      ACT_CLEAR_INT = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP_GAIN   = 3'd0,
      CSR_KI_GAIN   = 3'd1,
      CSR_KD_GAIN   = 3'd2,
      CSR_INT_LIMIT = 3'd3,
      CSR_OUT_LIMIT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  kp_gain;
      logic [GAIN_W-1:0]  ki_gain;
      logic [GAIN_W-1:0]  kd_gain;
      logic [LIMIT_W-1:0] integral_limit;
      logic [LIMIT_W-1:0] output_limit;
   } cfg_type;

   // Result of the error stage, handed to the gain stage.
   typedef struct packed {
      logic                     compute;
      logic signed [ERR_W-1:0]  err;
      logic [LIMIT_W-1:0]       sum;
      logic signed [DIFF_W-1:0] diff;
   } err_stage_type;

endpackage

### src/ppc_csr.sv
// Configuration registers of the PID controller: gains and limits.
// Depends on ppc_pkg.
`timescale 1ns / 1ps

module ppc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ppc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ppc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output ppc_pkg::cfg_type                 cfg
);
   import ppc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KP_GAIN:   cfg_in.kp_gain        = csr_wdata;
            CSR_KI_GAIN:   cfg_in.ki_gain        = csr_wdata;
            CSR_KD_GAIN:   cfg_in.kd_gain        = csr_wdata;
            CSR_INT_LIMIT: cfg_in.integral_limit = csr_wdata[LIMIT_W-1:0];
            CSR_OUT_LIMIT: cfg_in.output_limit   = csr_wdata[LIMIT_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_gain        <= KP_RESET;
         cfg_ff.ki_gain        <= KI_RESET;
         cfg_ff.kd_gain        <= KD_RESET;
         cfg_ff.integral_limit <= INT_LIMIT_RESET;
         cfg_ff.output_limit   <= OUT_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/ppc_front.sv
// Input register and error stage: error, clamped error sum, derivative difference.
// Holds the controller state (error sum, previous error). Depends on ppc_pkg.
`timescale 1ns / 1ps

module ppc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ppc_pkg::ACTION_W-1:0]        req_action,
   input  logic signed [ppc_pkg::SAMPLE_W-1:0] req_target,
   input  logic signed [ppc_pkg::SAMPLE_W-1:0] req_measured,
   input  ppc_pkg::cfg_type                    cfg,
   output logic                                out_valid,
   input  logic                                out_ready,
   output ppc_pkg::err_stage_type              out_data
);
   import ppc_pkg::*;

   logic                       in_valid_ff;
   logic [ACTION_W-1:0]        in_action_ff;
   logic signed [SAMPLE_W-1:0] in_target_ff;
   logic signed [SAMPLE_W-1:0] in_measured_ff;

   logic                       st_valid_ff;
   err_stage_type              st_data_ff;
   err_stage_type              st_data_in;

   logic [LIMIT_W-1:0]         error_sum_ff;
   logic [LIMIT_W-1:0]         error_sum_in;
   logic signed [ERR_W-1:0]    prev_err_ff;
   logic signed [ERR_W-1:0]    prev_err_in;

   logic                       st_ready;
   logic                       advance;
   logic                       accept;
   logic signed [ERR_W-1:0]    err;
   logic signed [DIFF_W-1:0]   sum_raw;
   logic signed [DIFF_W-1:0]   limit_ext;
   logic [LIMIT_W-1:0]         sum_clamped;
   logic signed [DIFF_W-1:0]   diff;

   assign st_ready  = !st_valid_ff || out_ready;
   assign advance   = in_valid_ff && st_ready;
   assign req_stall = in_valid_ff && !st_ready;
   assign accept    = req_valid && !req_stall;

   assign out_valid = st_valid_ff;
   assign out_data  = st_data_ff;

   always_comb begin
      err       = {in_target_ff[SAMPLE_W-1], in_target_ff}
                - {in_measured_ff[SAMPLE_W-1], in_measured_ff};
      sum_raw   = $signed({{(DIFF_W-LIMIT_W){1'b0}}, error_sum_ff}) + {err[ERR_W-1], err};
      limit_ext = $signed({{(DIFF_W-LIMIT_W){1'b0}}, cfg.integral_limit});
      // The upper clamp wins first, so a zero limit pins the sum at zero.
      if (sum_raw >= limit_ext) begin
         sum_clamped = cfg.integral_limit;
      end else if (sum_raw <= $signed({DIFF_W{1'b0}})) begin
         sum_clamped = '0;
      end else begin
         sum_clamped = sum_raw[LIMIT_W-1:0];
      end
      diff = {err[ERR_W-1], err} - {prev_err_ff[ERR_W-1], prev_err_ff};

      error_sum_in       = error_sum_ff;
      prev_err_in        = prev_err_ff;
      st_data_in.compute = 1'b0;
      st_data_in.err     = err;
      st_data_in.sum     = sum_clamped;
      st_data_in.diff    = diff;
      case (in_action_ff)
         ACT_COMPUTE: begin
            error_sum_in       = sum_clamped;
            prev_err_in        = err;
            st_data_in.compute = 1'b1;
         end
         ACT_CLEAR_ALL: begin
            error_sum_in = '0;
            prev_err_in  = '0;
         end
         ACT_CLEAR_INT: begin
            error_sum_in = '0;
         end
         default: begin
            error_sum_in = error_sum_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         st_valid_ff  <= 1'b0;
         error_sum_ff <= '0;
         prev_err_ff  <= '0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (st_ready) begin
            st_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            error_sum_ff <= error_sum_in;
            prev_err_ff  <= prev_err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_action_ff   <= req_action;
         in_target_ff   <= req_target;
         in_measured_ff <= req_measured;
      end
      if (advance) begin
         st_data_ff <= st_data_in;
      end
   end

endmodule

### src/ppc_gain.sv
// Gain stage: the three gain products, each shifted down by the fraction bits.
// The integral term is limited here. Depends on ppc_pkg.
`timescale 1ns / 1ps

module ppc_gain #(
   parameter int FRAC_BITS = ppc_pkg::DEFAULT_FRAC_BITS,
   parameter int P_W       = ppc_pkg::GAIN_W + ppc_pkg::ERR_W + 1 - FRAC_BITS,
   parameter int D_W       = ppc_pkg::GAIN_W + ppc_pkg::DIFF_W + 1 - FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ppc_pkg::cfg_type               cfg,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  ppc_pkg::err_stage_type         in_data,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic                           out_compute,
   output logic signed [P_W-1:0]          out_p,
   output logic [ppc_pkg::LIMIT_W-1:0]    out_i,
   output logic signed [D_W-1:0]          out_d
);
   import ppc_pkg::*;

   localparam int PF_W = GAIN_W + ERR_W + 1;
   localparam int IF_W = GAIN_W + LIMIT_W;
   localparam int DF_W = GAIN_W + DIFF_W + 1;

   logic                     valid_ff;
   logic                     compute_ff;
   logic signed [P_W-1:0]    p_ff;
   logic [LIMIT_W-1:0]       i_ff;
   logic signed [D_W-1:0]    d_ff;

   logic signed [PF_W-1:0]   p_full;
   logic signed [PF_W-1:0]   p_shift;
   logic [IF_W-1:0]          i_full;
   logic [IF_W-1:0]          i_shift;
   logic [LIMIT_W-1:0]       i_in;
   logic signed [DF_W-1:0]   d_full;
   logic signed [DF_W-1:0]   d_shift;
   logic                     load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   assign out_valid   = valid_ff;
   assign out_compute = compute_ff;
   assign out_p       = p_ff;
   assign out_i       = i_ff;
   assign out_d       = d_ff;

   always_comb begin
      p_full  = $signed({1'b0, cfg.kp_gain}) * in_data.err;
      p_shift = p_full >>> FRAC_BITS;
      i_full  = cfg.ki_gain * in_data.sum;
      i_shift = i_full >> FRAC_BITS;
      if (i_shift > {{(IF_W-LIMIT_W){1'b0}}, cfg.integral_limit}) begin
         i_in = cfg.integral_limit;
      end else begin
         i_in = i_shift[LIMIT_W-1:0];
      end
      d_full  = $signed({1'b0, cfg.kd_gain}) * in_data.diff;
      d_shift = d_full >>> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         compute_ff <= in_data.compute;
         p_ff       <= p_shift[P_W-1:0];
         i_ff       <= i_in;
         d_ff       <= d_shift[D_W-1:0];
      end
   end

endmodule

### src/ppc_out.sv
// Output stage: adds the three terms, clamps to 0..output_limit and holds the
// response register. Depends on ppc_pkg.
`timescale 1ns / 1ps

module ppc_out #(
   parameter int P_W = ppc_pkg::GAIN_W + ppc_pkg::ERR_W + 1 - ppc_pkg::DEFAULT_FRAC_BITS,
   parameter int D_W = ppc_pkg::GAIN_W + ppc_pkg::DIFF_W + 1 - ppc_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ppc_pkg::cfg_type               cfg,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic                           in_compute,
   input  logic signed [P_W-1:0]          in_p,
   input  logic [ppc_pkg::LIMIT_W-1:0]    in_i,
   input  logic signed [D_W-1:0]          in_d,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ppc_pkg::LIMIT_W-1:0]    rsp_drive
);
   import ppc_pkg::*;

   localparam int TOT_W = D_W + 2;

   logic                      rsp_valid_ff;
   logic [LIMIT_W-1:0]        drive_ff;
   logic [LIMIT_W-1:0]        drive_in;

   logic signed [TOT_W-1:0]   p_ext;
   logic signed [TOT_W-1:0]   i_ext;
   logic signed [TOT_W-1:0]   d_ext;
   logic signed [TOT_W-1:0]   limit_ext;
   logic signed [TOT_W-1:0]   total;
   logic                      load;

   assign in_ready  = !rsp_valid_ff || !rsp_stall;
   assign load      = in_valid && in_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = drive_ff;

   always_comb begin
      p_ext     = TOT_W'(in_p);
      i_ext     = TOT_W'($signed({1'b0, in_i}));
      d_ext     = TOT_W'(in_d);
      limit_ext = TOT_W'($signed({1'b0, cfg.output_limit}));
      total     = p_ext + i_ext + d_ext;
      // Clear requests and the unused action code give a zero drive.
      if (!in_compute) begin
         drive_in = '0;
      end else if (total > limit_ext) begin
         drive_in = cfg.output_limit;
      end else if (total <= $signed({TOT_W{1'b0}})) begin
         drive_in = '0;
      end else begin
         drive_in = total[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_ready) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         drive_ff <= drive_in;
      end
   end

endmodule

### src/positional_pid_clamped.sv
// Top level of the positional PID controller with clamped integral and output.
// Depends on ppc_pkg, ppc_csr, ppc_front, ppc_gain and ppc_out.
//
//   Channel   Ports                                      Direction
//   req       req_valid req_stall req_action/target/...  request in
//   rsp       rsp_valid rsp_stall rsp_drive              response out
//   csr       csr_valid csr_ready csr_index csr_wdata    register write in
//
// One request is taken every cycle while req_stall is low; its response passes the input
// register, error stage, gain stage and response register before it shows on rsp_valid.
// The error sum and previous error close their loop in the error stage.
// Reset is synchronous and clears the state, the valids and the registers to defaults.
// A stalled response holds each stage in turn, and req_stall rises once all are full.
`timescale 1ns / 1ps

module positional_pid_clamped #(
   parameter int GAIN_FRAC_BITS = ppc_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ppc_pkg::ACTION_W-1:0]        req_action,
   input  logic signed [ppc_pkg::SAMPLE_W-1:0] req_target,
   input  logic signed [ppc_pkg::SAMPLE_W-1:0] req_measured,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ppc_pkg::LIMIT_W-1:0]         rsp_drive,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ppc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ppc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ppc_pkg::*;

   localparam int P_W = GAIN_W + ERR_W + 1 - GAIN_FRAC_BITS;
   localparam int D_W = GAIN_W + DIFF_W + 1 - GAIN_FRAC_BITS;

   cfg_type               cfg;
   logic                  err_valid;
   logic                  err_ready;
   err_stage_type         err_data;
   logic                  gain_valid;
   logic                  gain_ready;
   logic                  gain_compute;
   logic signed [P_W-1:0] gain_p;
   logic [LIMIT_W-1:0]    gain_i;
   logic signed [D_W-1:0] gain_d;

   ppc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ppc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_target   (req_target),
      .req_measured (req_measured),
      .cfg          (cfg),
      .out_valid    (err_valid),
      .out_ready    (err_ready),
      .out_data     (err_data)
   );

   ppc_gain #(
      .FRAC_BITS (GAIN_FRAC_BITS),
      .P_W       (P_W),
      .D_W       (D_W)
   ) u_gain (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (err_valid),
      .in_ready    (err_ready),
      .in_data     (err_data),
      .out_valid   (gain_valid),
      .out_ready   (gain_ready),
      .out_compute (gain_compute),
      .out_p       (gain_p),
      .out_i       (gain_i),
      .out_d       (gain_d)
   );

   ppc_out #(
      .P_W (P_W),
      .D_W (D_W)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (gain_valid),
      .in_ready   (gain_ready),
      .in_compute (gain_compute),
      .in_p       (gain_p),
      .in_i       (gain_i),
      .in_d       (gain_d),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_drive  (rsp_drive)
   );

endmodule
